FILE: hw/rtl/bclc_pkg.sv
`timescale 1ns / 1ps

package bclc_pkg;

  // Field widths of the channels.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the threshold registers.
  localparam logic [TICK_W-1:0] LONG_PRESS_RST  = TICK_W'(50);
  localparam logic [TICK_W-1:0] SHORT_GAP_RST   = TICK_W'(30);
  localparam logic [TICK_W-1:0] RELEASE_RST     = TICK_W'(50);

  // Item operations.
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_POLL    = 2'd1,
    OP_RESET   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_SHORT_GAP  = 2'd1,
    CFG_RELEASE    = 2'd2
  } cfg_idx_t;

  // Classifier states, as reported on the result channel.
  typedef enum logic [STATE_W-1:0] {
    ST_IDLE       = 3'd0,
    ST_HELD       = 3'd1,
    ST_GAP        = 3'd2,
    ST_CLICK      = 3'd3,
    ST_LONG_PULSE = 3'd4,
    ST_LONG_HELD  = 3'd5,
    ST_RELEASE    = 3'd6
  } state_t;

  // Threshold set handed to the classifier core.
  typedef struct packed {
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] short_gap_ticks;
    logic [TICK_W-1:0] release_ticks;
  } thresh_t;

  // One accepted item as seen by the core.
  typedef struct packed {
    logic take;
    op_t  op;
    logic key_down;
  } item_t;

  // Values after the update, loaded into the result register.
  typedef struct packed {
    state_t             press_state;
    logic [COUNT_W-1:0] press_count;
  } result_t;

endpackage

FILE: hw/rtl/bclc_in_if.sv
`timescale 1ns / 1ps

interface bclc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bclc_pkg::OP_W-1:0]  operation;
  logic                       key_down;

  modport source (output valid, output operation, output key_down, input ready);
  modport sink   (input valid, input operation, input key_down, output ready);
endinterface

FILE: hw/rtl/bclc_out_if.sv
`timescale 1ns / 1ps

interface bclc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bclc_pkg::STATE_W-1:0]  press_state;
  logic [bclc_pkg::COUNT_W-1:0]  press_count;

  modport source (output valid, output press_state, output press_count, input ready);
  modport sink   (input valid, input press_state, input press_count, output ready);
endinterface

FILE: hw/rtl/bclc_cfg_if.sv
`timescale 1ns / 1ps

interface bclc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bclc_pkg::CFG_IDX_W-1:0]  index;
  logic [bclc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/bclc_core.sv
`timescale 1ns / 1ps

module bclc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  bclc_pkg::thresh_t thresh,
  input  bclc_pkg::item_t   item,
  output bclc_pkg::result_t result
);
  import bclc_pkg::*;

  state_t             state_r, state_nxt;
  logic [TICK_W-1:0]  elapsed_r, elapsed_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic over_long, over_short, over_release;

  // Threshold compares against the elapsed counter.
  assign over_long    = elapsed_r > thresh.long_press_ticks;
  assign over_short   = elapsed_r > thresh.short_gap_ticks;
  assign over_release = elapsed_r > thresh.release_ticks;

  // Next state of the classifier.
  always_comb begin
    state_nxt = state_r;
    case (item.op)
      OP_POLL: begin
        case (state_r)
          ST_HELD: begin
            if (!item.key_down) begin
              state_nxt = ST_GAP;
            end else if (over_long) begin
              state_nxt = ST_LONG_PULSE;
            end
          end
          ST_GAP: begin
            if (item.key_down) begin
              state_nxt = ST_HELD;
            end else if (over_short) begin
              state_nxt = ST_CLICK;
            end
          end
          ST_CLICK:      state_nxt = ST_IDLE;
          ST_LONG_PULSE: state_nxt = item.key_down ? ST_LONG_HELD : ST_RELEASE;
          ST_LONG_HELD: begin
            if (!item.key_down) begin
              state_nxt = ST_RELEASE;
            end else if (over_long) begin
              state_nxt = ST_LONG_PULSE;
            end
          end
          ST_RELEASE: begin
            if (!item.key_down && over_release) begin
              state_nxt = ST_IDLE;
            end
          end
          // Idle, and the unused code, which behaves as idle.
          default: state_nxt = item.key_down ? ST_HELD : ST_IDLE;
        endcase
      end
      OP_RESET:   state_nxt = ST_IDLE;
      OP_RELEASE: state_nxt = ST_RELEASE;
      default:    state_nxt = state_r;
    endcase
  end

  // Elapsed counter and press count updates.
  always_comb begin
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    case (item.op)
      OP_TICK: begin
        if (elapsed_r != {TICK_W{1'b1}}) begin
          elapsed_nxt = elapsed_r + TICK_W'(1);
        end
      end
      OP_POLL: begin
        case (state_r)
          ST_HELD: begin
            if (!item.key_down || over_long) begin
              count_nxt = count_r + COUNT_W'(1);
            end
          end
          ST_GAP: begin
            if (item.key_down) begin
              elapsed_nxt = '0;
            end
          end
          ST_CLICK:      elapsed_nxt = '0;
          ST_LONG_PULSE: elapsed_nxt = '0;
          ST_LONG_HELD: begin
            if (!item.key_down) begin
              elapsed_nxt = '0;
            end
          end
          ST_RELEASE: begin
            if (item.key_down) begin
              elapsed_nxt = '0;
            end
          end
          default: begin
            if (item.key_down) begin
              elapsed_nxt = '0;
            end
            count_nxt = '0;
          end
        endcase
      end
      OP_RESET: count_nxt = '0;
      default: begin
        elapsed_nxt = '0;
        count_nxt   = '0;
      end
    endcase
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      elapsed_r <= '0;
      count_r   <= '0;
    end else if (item.take) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
    end
  end

  assign result.press_state = state_nxt;
  assign result.press_count = count_nxt;

endmodule

FILE: hw/rtl/button_click_longpress_classifier.sv
`timescale 1ns / 1ps

// Channel  Direction  Fields
// in_ch    sink       operation[1:0], key_down
// out_ch   source     press_state[2:0], press_count[7:0]
// cfg_ch   sink       index[1:0], data[15:0]
//
// Each input beat is classified in the cycle it is accepted; its result
// appears in the result register on the next cycle, and one beat is taken
// every cycle while the result register is free or draining. The state
// update and threshold compares of the core feed the result register. Reset is
// synchronous and restores idle state, zero counters and default thresholds.
// When the result register is full and not being drained, in_ch.ready drops
// until it is taken. Configuration writes are always accepted.

module button_click_longpress_classifier (
  input  logic clk,
  input  logic rst_n,
  bclc_in_if.sink    in_ch,
  bclc_out_if.source out_ch,
  bclc_cfg_if.sink   cfg_ch
);
  import bclc_pkg::*;

  thresh_t thresh_r;
  item_t   item;
  result_t result;

  logic               out_valid_r;
  state_t             out_state_r;
  logic [COUNT_W-1:0] out_count_r;

  // Threshold registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.long_press_ticks <= LONG_PRESS_RST;
      thresh_r.short_gap_ticks  <= SHORT_GAP_RST;
      thresh_r.release_ticks    <= RELEASE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_LONG_PRESS: thresh_r.long_press_ticks <= cfg_ch.data;
        CFG_SHORT_GAP:  thresh_r.short_gap_ticks  <= cfg_ch.data;
        CFG_RELEASE:    thresh_r.release_ticks    <= cfg_ch.data;
        default:        thresh_r                  <= thresh_r;
      endcase
    end
  end

  // Accept a new beat whenever the result register is free or draining.
  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign item.take     = in_ch.valid && in_ch.ready;
  assign item.op       = op_t'(in_ch.operation);
  assign item.key_down = in_ch.key_down;

  bclc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .thresh (thresh_r),
    .item   (item),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item.take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.take) begin
      out_state_r <= result.press_state;
      out_count_r <= result.press_count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.press_state = out_state_r;
  assign out_ch.press_count = out_count_r;

endmodule
